### sv/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/i2cfr_pkg.sv
package i2cfr_pkg;

    localparam logic [1:0] SYM_START = 2'd0;
    localparam logic [1:0] SYM_CLOCK = 2'd1;
    localparam logic [1:0] SYM_STOP  = 2'd2;

    localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
    localparam logic [1:0] CFG_DATA_CTRL  = 2'd1;
    localparam logic [1:0] CFG_CMD_CTRL   = 2'd2;

    localparam logic [7:0] RST_SLAVE_ADDR = 8'd120;
    localparam logic [7:0] RST_DATA_CTRL  = 8'd64;
    localparam logic [7:0] RST_CMD_CTRL   = 8'd0;

    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // bit clocks 0..7 carry data, clock 8 is the unchecked ack slot
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic       run_end;
    } t_in_word;

    typedef struct packed {
        logic [1:0] bus_symbol;
        logic       sda_level;
        logic       ack_slot;
        logic       final_symbol;
    } t_out_word;

    typedef struct packed {
        logic [1:0] index;
        logic [7:0] data;
    } t_cfg_word;

    typedef struct packed {
        logic [7:0] slave_addr;
        logic [7:0] data_ctrl;
        logic [7:0] cmd_ctrl;
    } t_cfg_regs;

    // what the back end has to emit for one accepted word
    typedef struct packed {
        logic       pre_stop;
        logic       hdr;
        logic       is_cmd;
        logic [7:0] payload;
        logic       post_stop;
    } t_plan;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### sv/i2cfr_chan.sv
interface i2cfr_chan #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/i2cfr_front.sv
module i2cfr_front
    import i2cfr_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    i2cfr_chan.sink         i_in_ch,
    input  t_q_stat         i_q_stat,
    output logic            o_push,
    output t_plan           o_plan
);

    logic r_run_open;
    logic n_run_open;
    t_in_word w;

    assign w             = i_in_ch.data;
    assign i_in_ch.ready = !i_q_stat.full;
    assign o_push        = i_in_ch.valid && !i_q_stat.full;

    always_comb begin
        o_plan.payload = w.payload_byte;
        if (w.kind == KIND_CMD) begin
            // a command closes any open run, then is its own transaction
            o_plan.pre_stop  = r_run_open;
            o_plan.hdr       = 1'b1;
            o_plan.is_cmd    = 1'b1;
            o_plan.post_stop = 1'b1;
            n_run_open       = 1'b0;
        end else begin
            o_plan.pre_stop  = 1'b0;
            o_plan.hdr       = !r_run_open;
            o_plan.is_cmd    = 1'b0;
            o_plan.post_stop = w.run_end;
            n_run_open       = !w.run_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open <= 1'b0;
        end else if (o_push) begin
            r_run_open <= n_run_open;
        end
    end

endmodule

### sv/i2cfr_queue.sv
module i2cfr_queue
    import i2cfr_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_plan   i_plan,
    input  logic    i_pop,
    output t_plan   o_head,
    output t_q_stat o_stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_plan         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_plan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### sv/i2cfr_back.sv
module i2cfr_back
    import i2cfr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg_regs i_cfg,
    input  t_plan     i_head,
    input  t_q_stat   i_q_stat,
    output logic      o_pop,
    i2cfr_chan.source o_out_ch
);

    // sequencer phases; PH_FIRST means pick the entry phase from the queue head
    localparam logic [2:0] PH_FIRST   = 3'd0;
    localparam logic [2:0] PH_PRESTOP = 3'd1;
    localparam logic [2:0] PH_START   = 3'd2;
    localparam logic [2:0] PH_ADDR    = 3'd3;
    localparam logic [2:0] PH_CTRL    = 3'd4;
    localparam logic [2:0] PH_DATA    = 3'd5;
    localparam logic [2:0] PH_STOP    = 3'd6;

    logic [2:0] r_phase;
    logic [2:0] n_phase;
    logic [3:0] r_bit;
    logic [3:0] n_bit;
    logic [2:0] cur;
    logic [2:0] nxt;
    logic [7:0] cur_byte;
    logic       is_byte;
    logic       is_ack;
    logic       emit;
    t_out_word  sym;
    t_out_word  r_out;
    logic       r_out_valid;

    assign emit           = !i_q_stat.empty && (!r_out_valid || o_out_ch.ready);
    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.data  = r_out;
    assign is_ack         = (r_bit == BITS_PER_BYTE);

    always_comb begin
        cur = r_phase;
        if (r_phase == PH_FIRST) begin
            cur = i_head.pre_stop ? PH_PRESTOP : (i_head.hdr ? PH_START : PH_DATA);
        end

        case (cur)
            PH_ADDR: cur_byte = i_cfg.slave_addr;
            PH_CTRL: cur_byte = i_head.is_cmd ? i_cfg.cmd_ctrl : i_cfg.data_ctrl;
            default: cur_byte = i_head.payload;
        endcase

        sym     = '0;
        is_byte = 1'b0;
        case (cur)
            PH_PRESTOP: begin
                sym.bus_symbol = SYM_STOP;
                sym.sda_level  = 1'b1;
                nxt            = PH_START;
            end
            PH_START: begin
                sym.bus_symbol = SYM_START;
                nxt            = PH_ADDR;
            end
            PH_ADDR, PH_CTRL, PH_DATA: begin
                is_byte        = 1'b1;
                sym.bus_symbol = SYM_CLOCK;
                sym.ack_slot   = is_ack;
                // ack slot keeps the last bit on SDA
                sym.sda_level  = is_ack ? cur_byte[0] : cur_byte[3'd7 - r_bit[2:0]];
                sym.final_symbol = (cur == PH_DATA) && is_ack && !i_head.post_stop;
                if (cur == PH_ADDR) begin
                    nxt = PH_CTRL;
                end else if (cur == PH_CTRL) begin
                    nxt = PH_DATA;
                end else begin
                    nxt = i_head.post_stop ? PH_STOP : PH_FIRST;
                end
            end
            PH_STOP: begin
                sym.bus_symbol   = SYM_STOP;
                sym.sda_level    = 1'b1;
                sym.final_symbol = 1'b1;
                nxt              = PH_FIRST;
            end
            default: begin
                nxt = PH_FIRST;
            end
        endcase

        n_phase = r_phase;
        n_bit   = r_bit;
        o_pop   = 1'b0;
        if (emit) begin
            if (is_byte && !is_ack) begin
                n_bit   = r_bit + 1'b1;
                n_phase = cur;
            end else begin
                n_bit   = '0;
                n_phase = nxt;
                o_pop   = (nxt == PH_FIRST);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FIRST;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= sym;
        end
    end

endmodule

### sv/i2c_write_only_display_framer_core.sv
// The first bus symbol of a word passes through the plan queue and then the output
// register before it is presented. The back-end sequencer emits one symbol per cycle
// while the queue holds a word and the output is not stalled.
// The plan queue lets input words be taken while earlier symbols still drain.
// Reset (synchronous, active low) closes any run, empties the queue and restores
// the register defaults.
`include "assert_macros.svh"

module i2c_write_only_display_framer_core
    import i2cfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    i2cfr_chan.sink   i_in_ch,
    i2cfr_chan.sink   i_cfg_ch,
    i2cfr_chan.source o_out_ch
);

    t_cfg_regs r_cfg;
    t_cfg_word cfg_w;
    t_plan     plan;
    t_plan     head;
    t_q_stat   q_stat;
    logic      push;
    logic      pop;
    t_out_word out_w;
    logic      out_final_clk;
    logic      out_start;

    assign cfg_w          = i_cfg_ch.data;
    assign i_cfg_ch.ready = 1'b1;
    assign out_w          = o_out_ch.data;
    assign out_final_clk  = o_out_ch.valid && out_w.final_symbol
                            && (out_w.bus_symbol == SYM_CLOCK);
    assign out_start      = o_out_ch.valid && (out_w.bus_symbol == SYM_START);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_addr <= RST_SLAVE_ADDR;
            r_cfg.data_ctrl  <= RST_DATA_CTRL;
            r_cfg.cmd_ctrl   <= RST_CMD_CTRL;
        end else if (i_cfg_ch.valid) begin
            case (cfg_w.index)
                CFG_SLAVE_ADDR: r_cfg.slave_addr <= cfg_w.data;
                CFG_DATA_CTRL:  r_cfg.data_ctrl  <= cfg_w.data;
                CFG_CMD_CTRL:   r_cfg.cmd_ctrl   <= cfg_w.data;
                default: ;
            endcase
        end
    end

    i2cfr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (i_in_ch),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_plan   (plan)
    );

    i2cfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_plan  (plan),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    i2cfr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out_ch (o_out_ch)
    );

    `AST_NEXT(a_push_lands, i_clk, i_rst_n, i_in_ch.valid && i_in_ch.ready, !q_stat.empty)
    `AST_IMPL(a_pop_needs_entry, i_clk, i_rst_n, pop, !q_stat.empty)
    `AST_IMPL(a_final_clock_is_ack, i_clk, i_rst_n, out_final_clk, out_w.ack_slot)
    `AST_IMPL(a_start_low, i_clk, i_rst_n, out_start, !out_w.sda_level && !out_w.final_symbol)

endmodule
